>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LTR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define LTR_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

>>> sv/ltr_pkg.sv
// Package with the types, constants and register codes of the timer re-arm unit.
package ltr_pkg;

   // Width of the hardware down-counter that takes the reload values
   localparam int COUNTER_BITS = 16;

   localparam int DELTA_W  = 64;
   localparam int PERIOD_W = 30;
   localparam int MAX_W    = 16;
   localparam int STEP_W   = 30;

   // Mask applied to max_ticks before use
   localparam logic [MAX_W-1:0] MAX_MASK = MAX_W'((64'd1 << COUNTER_BITS) - 64'd1);

   // Register reset values
   localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = PERIOD_W'(838);
   localparam logic [MAX_W-1:0]    MAX_TICKS_RST   = MAX_W'(65535);
   localparam logic [STEP_W-1:0]   CLOCK_STEP_RST  = STEP_W'(10000000);

   // Register indexes on the configuration port
   typedef enum logic [1:0] {
      CSR_TICK_PERIOD = 2'd0,
      CSR_MAX_TICKS   = 2'd1,
      CSR_CLOCK_MODE  = 2'd2,
      CSR_CLOCK_STEP  = 2'd3
   } csr_index_type;

   // Request operation codes
   typedef enum logic {
      OP_ARM  = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_TICKS,
      ST_SPLIT,
      ST_DIV_ARMS,
      ST_TICK,
      ST_EMIT
   } ltr_state_type;

   // Control between sequencer and divider
   typedef struct packed {
      logic start;
   } div_req_type;

   typedef struct packed {
      logic done;
   } div_rsp_type;

endpackage

>>> sv/ltr_div.sv
// Radix-2 restoring divider: 64-bit dividend by 30-bit divisor, one quotient bit a cycle.
module ltr_div
   import ltr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  div_req_type         ctl,
   input  logic [DELTA_W-1:0]  dividend,
   input  logic [PERIOD_W-1:0] divisor,
   output div_rsp_type         sts,
   output logic [DELTA_W-1:0]  quotient,
   output logic [PERIOD_W-1:0] remainder
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [5:0]          step_ff, step_in;
   logic [DELTA_W-1:0]  quo_ff, quo_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W-1:0] dvs_ff, dvs_in;

   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W+1:0] diff;
   logic                fits;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DELTA_W-1]};
      diff  = {1'b0, trial} - {2'b00, dvs_ff};
      fits  = ~diff[PERIOD_W+1];
   end

   // Advance one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         step_in = 6'd63;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DELTA_W-2:0], fits};
         rem_in  = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         step_in = step_ff - 6'd1;
         if (step_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> sv/long_interval_timer_rearm.sv
// Arm: one 64-step pass of the shared divider from request to result when the delay fits
//   the maximum, two when it is split into re-arms.
// Tick: one update state, then one emit state, from request to result.
// One request at a time: req_ready returns in the cycle after the result is loaded, later while
//   a stalled result holds the output register. Synchronous active-high reset, no clearing pass.
// Top level of the long-interval one-shot timer re-arm unit.
module long_interval_timer_rearm
   import ltr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [DELTA_W-1:0]  req_delta_ns,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_reload_valid,
   output logic [MAX_W-1:0]    rsp_reload_ticks,
   output logic                rsp_deadline_due,
   output logic [DELTA_W-1:0]  rsp_clock_time_ns,
   // configuration port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   // Configuration registers
   logic [PERIOD_W-1:0] period_ff;
   logic [MAX_W-1:0]    max_ff;
   logic                mode_ff;
   logic [STEP_W-1:0]   step_ff;
   csr_index_type       csr_idx;
   logic                csr_wr;

   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= TICK_PERIOD_RST;
         max_ff    <= MAX_TICKS_RST;
         mode_ff   <= 1'b0;
         step_ff   <= CLOCK_STEP_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_TICK_PERIOD: period_ff <= csr_pwdata[PERIOD_W-1:0];
            CSR_MAX_TICKS:   max_ff    <= csr_pwdata[MAX_W-1:0];
            CSR_CLOCK_MODE:  mode_ff   <= csr_pwdata[0];
            CSR_CLOCK_STEP:  step_ff   <= csr_pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back configuration
   always_comb begin
      case (csr_idx)
         CSR_TICK_PERIOD: csr_prdata = {{(32-PERIOD_W){1'b0}}, period_ff};
         CSR_MAX_TICKS:   csr_prdata = {{(32-MAX_W){1'b0}}, max_ff};
         CSR_CLOCK_MODE:  csr_prdata = {31'd0, mode_ff};
         CSR_CLOCK_STEP:  csr_prdata = {{(32-STEP_W){1'b0}}, step_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Effective divisor and counter maximum
   logic [PERIOD_W-1:0] per;
   logic [MAX_W-1:0]    max_masked;
   logic [MAX_W-1:0]    eff_max;

   assign per        = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign max_masked = max_ff & MAX_MASK;
   assign eff_max    = (max_masked == '0) ? MAX_W'(1) : max_masked;

   // Shared divider
   div_req_type         div_ctl;
   div_rsp_type         div_sts;
   logic [DELTA_W-1:0]  div_dividend;
   logic [PERIOD_W-1:0] div_divisor;
   logic [DELTA_W-1:0]  div_quo;
   logic [PERIOD_W-1:0] div_rem;

   ltr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .sts       (div_sts),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Sequencer and timer state
   ltr_state_type       state_ff, state_in;
   logic [DELTA_W-1:0]  ticks_ff, ticks_in;
   logic [DELTA_W-1:0]  arms_ff, arms_in;
   logic [MAX_W-1:0]    final_ff, final_in;
   logic [DELTA_W-1:0]  clock_ff, clock_in;
   logic                res_rv_ff, res_rv_in;
   logic [MAX_W-1:0]    res_ticks_ff, res_ticks_in;
   logic                res_due_ff, res_due_in;
   logic                out_v_ff, out_v_in;
   logic                out_rv_ff, out_rv_in;
   logic [MAX_W-1:0]    out_ticks_ff, out_ticks_in;
   logic                out_due_ff, out_due_in;
   logic [DELTA_W-1:0]  out_clock_ff, out_clock_in;
   logic [DELTA_W-1:0]  arms_dec;

   assign arms_dec = arms_ff - DELTA_W'(1);

   // Next state, divider control and result build
   always_comb begin
      state_in     = state_ff;
      ticks_in     = ticks_ff;
      arms_in      = arms_ff;
      final_in     = final_ff;
      clock_in     = clock_ff;
      res_rv_in    = res_rv_ff;
      res_ticks_in = res_ticks_ff;
      res_due_in   = res_due_ff;
      out_v_in     = out_v_ff;
      out_rv_in    = out_rv_ff;
      out_ticks_in = out_ticks_ff;
      out_due_in   = out_due_ff;
      out_clock_in = out_clock_ff;
      div_ctl      = '0;
      div_dividend = req_delta_ns;
      div_divisor  = per;
      req_ready    = 1'b0;

      // drop the result once taken
      if (out_v_ff && rsp_ready) begin
         out_v_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (op_type'(req_operation) == OP_ARM) begin
                  div_ctl.start = 1'b1;
                  state_in      = ST_DIV_TICKS;
               end else begin
                  state_in = ST_TICK;
               end
            end
         end
         ST_DIV_TICKS: begin
            if (div_sts.done) begin
               ticks_in = (div_quo == '0) ? DELTA_W'(1) : div_quo;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            // split into full re-arms plus remainder when above the maximum
            res_rv_in  = 1'b1;
            res_due_in = 1'b0;
            if (ticks_ff > DELTA_W'(eff_max)) begin
               div_ctl.start = 1'b1;
               div_dividend  = ticks_ff;
               div_divisor   = PERIOD_W'(eff_max);
               res_ticks_in  = eff_max;
               state_in      = ST_DIV_ARMS;
            end else begin
               arms_in      = '0;
               final_in     = '0;
               res_ticks_in = ticks_ff[MAX_W-1:0];
               state_in     = ST_EMIT;
            end
         end
         ST_DIV_ARMS: begin
            if (div_sts.done) begin
               arms_in  = div_quo;
               final_in = div_rem[MAX_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_TICK: begin
            // advance the clock when enabled and consume one re-arm, or report the deadline when none is left
            if (mode_ff) begin
               clock_in = clock_ff + DELTA_W'(step_ff);
            end
            if (arms_ff != '0) begin
               arms_in      = arms_dec;
               res_rv_in    = 1'b1;
               res_due_in   = 1'b0;
               res_ticks_in = (arms_dec != '0) ? eff_max : final_ff;
            end else begin
               res_rv_in    = 1'b0;
               res_due_in   = 1'b1;
               res_ticks_in = '0;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!out_v_ff || rsp_ready) begin
               out_v_in     = 1'b1;
               out_rv_in    = res_rv_ff;
               out_ticks_in = res_ticks_ff;
               out_due_in   = res_due_ff;
               out_clock_in = clock_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         arms_ff  <= '0;
         final_ff <= '0;
         clock_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         arms_ff  <= arms_in;
         final_ff <= final_in;
         clock_ff <= clock_in;
         out_v_ff <= out_v_in;
      end
      ticks_ff     <= ticks_in;
      res_rv_ff    <= res_rv_in;
      res_ticks_ff <= res_ticks_in;
      res_due_ff   <= res_due_in;
      out_rv_ff    <= out_rv_in;
      out_ticks_ff <= out_ticks_in;
      out_due_ff   <= out_due_in;
      out_clock_ff <= out_clock_in;
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_reload_valid  = out_rv_ff;
   assign rsp_reload_ticks  = out_ticks_ff;
   assign rsp_deadline_due  = out_due_ff;
   assign rsp_clock_time_ns = out_clock_ff;

endmodule

>>> sv/ltr_chk.sv
// Port-level checker for the timer re-arm unit, bound to the top level.
`include "assert_macros.svh"

module ltr_chk
   import ltr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_reload_valid,
   input logic [MAX_W-1:0]   rsp_reload_ticks,
   input logic               rsp_deadline_due,
   input logic [DELTA_W-1:0] rsp_clock_time_ns
);

   // A result either reloads the counter or reports the deadline, never both
   `LTR_ASSERT(a_one_outcome, rsp_valid |-> (rsp_reload_valid ^ rsp_deadline_due), "reload and deadline both or neither")

   // No reload value without a reload
   `LTR_ASSERT_NEVER(a_idle_ticks, rsp_valid && !rsp_reload_valid && (rsp_reload_ticks != '0), "reload ticks set without reload")

   // One request at a time: the block is busy right after taking one
   `LTR_ASSERT(a_busy_after_req, (req_valid && req_ready) |=> !req_ready, "request taken while busy")

   // A stalled result holds
   `LTR_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_clock_time_ns) && $stable(rsp_reload_ticks)), "stalled result changed")

endmodule

bind long_interval_timer_rearm ltr_chk u_ltr_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_reload_valid  (rsp_reload_valid),
   .rsp_reload_ticks  (rsp_reload_ticks),
   .rsp_deadline_due  (rsp_deadline_due),
   .rsp_clock_time_ns (rsp_clock_time_ns)
);

>>> tb/tb_top.sv
// Self-checking testbench for the long-interval timer re-arm unit.
module tb_top;
   import ltr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // One result of the unit, as seen on the response channel
   typedef struct packed {
      logic               reload_valid;
      logic [MAX_W-1:0]   reload_ticks;
      logic               deadline_due;
      logic [DELTA_W-1:0] clock_time_ns;
   } timer_result_type;

   typedef enum logic {
      ROW_REQUEST,
      ROW_CSR
   } row_kind_type;

   // One line of the directed table
   typedef struct {
      row_kind_type       kind;
      op_type             op;
      logic [DELTA_W-1:0] delta;
      csr_index_type      reg_index;
      logic [31:0]        reg_value;
      logic               pinned;
      timer_result_type   result;
   } stim_row_type;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 130;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_operation = 1'b0;
   logic [DELTA_W-1:0] req_delta_ns = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_reload_valid;
   logic [MAX_W-1:0]   rsp_reload_ticks;
   logic               rsp_deadline_due;
   logic [DELTA_W-1:0] rsp_clock_time_ns;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   // Shadow copy of the unit's registers and state
   logic [PERIOD_W-1:0] cfg_period;
   logic [MAX_W-1:0]    cfg_max;
   logic                cfg_clock_mode;
   logic [STEP_W-1:0]   cfg_clock_step;
   logic [63:0]         pending_rearms;
   logic [MAX_W-1:0]    last_reload;
   logic [63:0]         wall_clock_ns;

   timer_result_type expected_reloads[$];
   stim_row_type     directed_rows[$];
   int               mismatch_count = 0;
   int               next_gap = 0;
   int               stall_left = 0;
   bit               steady_flow = 1'b0;

   long_interval_timer_rearm dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_delta_ns      (req_delta_ns),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_reload_valid  (rsp_reload_valid),
      .rsp_reload_ticks  (rsp_reload_ticks),
      .rsp_deadline_due  (rsp_deadline_due),
      .rsp_clock_time_ns (rsp_clock_time_ns),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t ns mismatch %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [63:0] eff_period();
      return (cfg_period == '0) ? 64'd1 : 64'(cfg_period);
   endfunction

   function automatic logic [63:0] eff_max();
      logic [MAX_W-1:0] masked;
      masked = cfg_max & MAX_MASK;
      return (masked == '0) ? 64'd1 : 64'(masked);
   endfunction

   // Advance the shadow state by one request and return the result it causes
   function automatic timer_result_type advance_timer(op_type op, logic [63:0] delta);
      timer_result_type res;
      logic [63:0]      ticks;
      logic [63:0]      span;
      res = '0;
      span = eff_max();
      if (op == OP_ARM) begin
         ticks = delta / eff_period();
         if (ticks == 0) ticks = 64'd1;
         pending_rearms = '0;
         last_reload = '0;
         // split an overlong delay into full re-arms plus a remainder
         if (ticks > span) begin
            pending_rearms = ticks / span;
            last_reload = MAX_W'(ticks % span);
            ticks = span;
         end
         res.reload_valid = 1'b1;
         res.reload_ticks = MAX_W'(ticks);
      end else begin
         if (cfg_clock_mode) wall_clock_ns += 64'(cfg_clock_step);
         if (pending_rearms != 0) begin
            pending_rearms--;
            res.reload_valid = 1'b1;
            res.reload_ticks = (pending_rearms != 0) ? MAX_W'(span) : last_reload;
         end else begin
            res.deadline_due = 1'b1;
         end
      end
      res.clock_time_ns = wall_clock_ns;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      if (r < 97) return $urandom_range(5, 40);
      return $urandom_range(100, 300);
   endfunction

   // Present one request, hold it until accepted, then queue its expected result
   task automatic send_request(op_type op, logic [63:0] delta, logic pinned,
                               timer_result_type pinned_result);
      timer_result_type predicted;
      repeat (next_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_operation <= op;
      req_delta_ns <= delta;
      do @(posedge clock); while (!req_ready);
      predicted = advance_timer(op, delta);
      expected_reloads.push_back(pinned ? pinned_result : predicted);
      next_gap = pick_gap();
      if (next_gap != 0) req_valid <= 1'b0;
   endtask

   // Drop valid if the last request left it raised for a back-to-back follow-up
   task automatic idle_request();
      if (next_gap == 0) begin
         req_valid <= 1'b0;
         next_gap = 1;
      end
   endtask

   task automatic wait_drained();
      while (expected_reloads.size() != 0) @(posedge clock);
   endtask

   // Setup and access phase, then an idle phase on the bus
   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         CSR_TICK_PERIOD: cfg_period = value[PERIOD_W-1:0];
         CSR_MAX_TICKS:   cfg_max = value[MAX_W-1:0];
         CSR_CLOCK_MODE:  cfg_clock_mode = value[0];
         CSR_CLOCK_STEP:  cfg_clock_step = value[STEP_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic stim_row_type req_row(op_type op, logic [63:0] delta);
      stim_row_type row;
      row.kind = ROW_REQUEST;
      row.op = op;
      row.delta = delta;
      row.reg_index = CSR_TICK_PERIOD;
      row.reg_value = '0;
      row.pinned = 1'b0;
      row.result = '0;
      return row;
   endfunction

   function automatic stim_row_type pin_row(op_type op, logic [63:0] delta, logic valid,
                                            logic [15:0] ticks, logic due, logic [63:0] clk);
      stim_row_type row;
      row = req_row(op, delta);
      row.pinned = 1'b1;
      row.result.reload_valid = valid;
      row.result.reload_ticks = ticks;
      row.result.deadline_due = due;
      row.result.clock_time_ns = clk;
      return row;
   endfunction

   function automatic stim_row_type cfg_row(csr_index_type idx, logic [31:0] value);
      stim_row_type row;
      row = req_row(OP_ARM, '0);
      row.kind = ROW_CSR;
      row.reg_index = idx;
      row.reg_value = value;
      return row;
   endfunction

   // Accept results with random stalls and check them against the oldest expectation
   always @(posedge clock) begin : check_results
      timer_result_type want;
      int               pick;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reloads.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_reload_ticks), 64'd0);
         end else begin
            want = expected_reloads.pop_front();
            if (rsp_reload_valid !== want.reload_valid)
               report_mismatch("reload_valid", 64'(rsp_reload_valid), 64'(want.reload_valid));
            if (rsp_reload_ticks !== want.reload_ticks)
               report_mismatch("reload_ticks", 64'(rsp_reload_ticks), 64'(want.reload_ticks));
            if (rsp_deadline_due !== want.deadline_due)
               report_mismatch("deadline_due", 64'(rsp_deadline_due), 64'(want.deadline_due));
            if (rsp_clock_time_ns !== want.clock_time_ns)
               report_mismatch("clock_time_ns", rsp_clock_time_ns, want.clock_time_ns);
         end
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 99) < 15) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            stall_left = $urandom_range(0, 2);
         end else if (pick < 97) begin
            stall_left = $urandom_range(3, 29);
         end else begin
            stall_left = $urandom_range(49, 249);
         end
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Hard stop well past the slowest legal run
   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      op_type      op;
      logic [63:0] delta;
      logic [63:0] per;
      logic [63:0] span;
      logic [63:0] rest;
      int          sent;
      int          burst;
      int          drain_cycles;

      cfg_period = TICK_PERIOD_RST;
      cfg_max = MAX_TICKS_RST;
      cfg_clock_mode = 1'b0;
      cfg_clock_step = CLOCK_STEP_RST;
      pending_rearms = '0;
      last_reload = '0;
      wall_clock_ns = '0;

      // Reset values: period 838, maximum 65535, clock off
      directed_rows.push_back(pin_row(OP_TICK, '0, 1'b0, 16'd0, 1'b1, 64'd0));
      directed_rows.push_back(pin_row(OP_ARM, 64'd0, 1'b1, 16'd1, 1'b0, 64'd0));
      directed_rows.push_back(pin_row(OP_ARM, 64'd837, 1'b1, 16'd1, 1'b0, 64'd0));
      directed_rows.push_back(pin_row(OP_ARM, 64'd838, 1'b1, 16'd1, 1'b0, 64'd0));
      directed_rows.push_back(pin_row(OP_ARM, 64'd838 * 64'd65535, 1'b1, 16'hFFFF, 1'b0,
                                      64'd0));
      // one tick past the maximum: one re-arm with a remainder of one
      directed_rows.push_back(pin_row(OP_ARM, 64'd838 * 64'd65536, 1'b1, 16'hFFFF, 1'b0,
                                      64'd0));
      directed_rows.push_back(pin_row(OP_TICK, ALL_ONES, 1'b1, 16'd1, 1'b0, 64'd0));
      directed_rows.push_back(pin_row(OP_TICK, '0, 1'b0, 16'd0, 1'b1, 64'd0));
      directed_rows.push_back(pin_row(OP_ARM, ALL_ONES, 1'b1, 16'hFFFF, 1'b0, 64'd0));
      directed_rows.push_back(pin_row(OP_TICK, '0, 1'b1, 16'hFFFF, 1'b0, 64'd0));
      // new arm drops the pending re-arms
      directed_rows.push_back(pin_row(OP_ARM, 64'd0, 1'b1, 16'd1, 1'b0, 64'd0));
      directed_rows.push_back(pin_row(OP_TICK, '0, 1'b0, 16'd0, 1'b1, 64'd0));
      // exact multiple of the maximum: last re-arm reloads zero
      directed_rows.push_back(pin_row(OP_ARM, 64'd838 * 64'd131070, 1'b1, 16'hFFFF, 1'b0,
                                      64'd0));
      directed_rows.push_back(pin_row(OP_TICK, '0, 1'b1, 16'hFFFF, 1'b0, 64'd0));
      directed_rows.push_back(pin_row(OP_TICK, '0, 1'b1, 16'd0, 1'b0, 64'd0));
      directed_rows.push_back(pin_row(OP_TICK, '0, 1'b0, 16'd0, 1'b1, 64'd0));
      // zero period and zero maximum both act as one; clock on with a one-second step
      directed_rows.push_back(cfg_row(CSR_TICK_PERIOD, 32'd0));
      directed_rows.push_back(cfg_row(CSR_MAX_TICKS, 32'd0));
      directed_rows.push_back(cfg_row(CSR_CLOCK_MODE, 32'd1));
      directed_rows.push_back(cfg_row(CSR_CLOCK_STEP, 32'd1_000_000_000));
      directed_rows.push_back(pin_row(OP_ARM, 64'd3, 1'b1, 16'd1, 1'b0, 64'd0));
      directed_rows.push_back(pin_row(OP_TICK, '0, 1'b1, 16'd1, 1'b0, 64'd1_000_000_000));
      directed_rows.push_back(pin_row(OP_TICK, '0, 1'b1, 16'd1, 1'b0, 64'd2_000_000_000));
      directed_rows.push_back(pin_row(OP_TICK, '0, 1'b1, 16'd0, 1'b0, 64'd3_000_000_000));
      directed_rows.push_back(pin_row(OP_TICK, '0, 1'b0, 16'd0, 1'b1, 64'd4_000_000_000));
      // widest period, odd maximum, zero step, then the widest step
      directed_rows.push_back(cfg_row(CSR_TICK_PERIOD, 32'hFFFF_FFFF));
      directed_rows.push_back(cfg_row(CSR_MAX_TICKS, 32'd12345));
      directed_rows.push_back(cfg_row(CSR_CLOCK_STEP, 32'd0));
      directed_rows.push_back(req_row(OP_ARM, ALL_ONES));
      directed_rows.push_back(req_row(OP_TICK, ALL_ONES));
      directed_rows.push_back(cfg_row(CSR_CLOCK_STEP, 32'hFFFF_FFFF));
      directed_rows.push_back(req_row(OP_TICK, '0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      next_gap = pick_gap();

      // Walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            idle_request();
            wait_drained();
            csr_write(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_request(directed_rows[i].op, directed_rows[i].delta,
                         directed_rows[i].pinned, directed_rows[i].result);
         end
      end

      // Random phases, each under its own register setting
      sent = 0;
      for (int p = 0; p < PHASES; p++) begin
         idle_request();
         wait_drained();
         steady_flow = (p == 3 || p == 7);
         case (p)
            0: csr_write(CSR_TICK_PERIOD, 32'd838);
            1: csr_write(CSR_TICK_PERIOD, 32'd0);
            2: csr_write(CSR_TICK_PERIOD, 32'd1);
            3: csr_write(CSR_TICK_PERIOD, 32'd1_000_000_000);
            4: csr_write(CSR_TICK_PERIOD, 32'hFFFF_FFFF);
            default: csr_write(CSR_TICK_PERIOD, $urandom_range(0, 1) ? $urandom
                                                 : $urandom_range(1, 5000));
         endcase
         case (p)
            0: csr_write(CSR_MAX_TICKS, 32'd65535);
            1: csr_write(CSR_MAX_TICKS, 32'd0);
            2: csr_write(CSR_MAX_TICKS, 32'd1);
            3: csr_write(CSR_MAX_TICKS, 32'd65535);
            4: csr_write(CSR_MAX_TICKS, $urandom_range(2, 40));
            default: csr_write(CSR_MAX_TICKS, $urandom_range(0, 1) ? $urandom
                                               : $urandom_range(1, 300));
         endcase
         case (p)
            0: csr_write(CSR_CLOCK_MODE, 32'd0);
            1: csr_write(CSR_CLOCK_MODE, 32'd1);
            default: csr_write(CSR_CLOCK_MODE, $urandom);
         endcase
         case (p)
            0: csr_write(CSR_CLOCK_STEP, 32'd10_000_000);
            1: csr_write(CSR_CLOCK_STEP, 32'd1_000_000_000);
            2: csr_write(CSR_CLOCK_STEP, 32'hFFFF_FFFF);
            3: csr_write(CSR_CLOCK_STEP, 32'd0);
            default: csr_write(CSR_CLOCK_STEP, $urandom);
         endcase

         while (sent < (p + 1) * PHASE_ITEMS) begin
            // now and then hold the sender until every result is back
            if ($urandom_range(0, 199) == 0) begin
               idle_request();
               wait_drained();
            end
            if ($urandom_range(0, 99) < 80) begin
               // arm a delay under four maxima long, then send a random number of ticks
               per = eff_period();
               span = eff_max();
               burst = $urandom_range(0, 3);
               rest = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(0, 32'(span - 1)));
               delta = per * (64'(burst) * span + rest) + 64'($urandom_range(0, 32'(per - 1)));
               send_request(OP_ARM, delta, 1'b0, '0);
               sent++;
               repeat ($urandom_range(0, burst + 2)) begin
                  send_request(OP_TICK, {$urandom, $urandom}, 1'b0, '0);
                  sent++;
               end
            end else begin
               // lone request with raw content
               op = $urandom_range(0, 1) ? OP_TICK : OP_ARM;
               case ($urandom_range(0, 9))
                  0, 1:    delta = '0;
                  2:       delta = ALL_ONES;
                  default: delta = {$urandom, $urandom};
               endcase
               send_request(op, delta, 1'b0, '0);
               sent++;
            end
         end
      end

      // Drain, then let the unit settle
      idle_request();
      steady_flow = 1'b0;
      drain_cycles = 0;
      while (expected_reloads.size() != 0 && drain_cycles < 200_000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (expected_reloads.size() != 0)
         report_mismatch("results missing", 64'(expected_reloads.size()), 64'd0);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_reloads.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
